// ----- hdl/tlcr_pkg.sv -----
// Shared types and constants of the text line character rasterizer.
package tlcr_pkg;

    // Configuration port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Pixels and characters of one output word.
    localparam int CHARS_PER_WORD = 4;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = CHARS_PER_WORD * BYTE_W;

    // Saturation point of the word position counter.
    localparam logic [7:0] WORD_POS_MAX = 8'hFF;

    // Register reset values.
    localparam logic [7:0] FIRST_CHAR_RST     = 8'd32;
    localparam logic [9:0] CHARS_PER_LINE_RST = 10'd80;
    localparam logic [7:0] GFX_START_RST      = 8'd0;
    localparam logic [7:0] GFX_LEN_RST        = 8'd0;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_FIRST_CHAR     = 2'd0,
        REG_CHARS_PER_LINE = 2'd1,
        REG_GFX_START_WORD = 2'd2,
        REG_GFX_LEN_WORDS  = 2'd3
    } reg_idx_t;

    // Item kinds.
    typedef enum logic {
        ACT_FONT_WRITE = 1'b0,
        ACT_RASTER     = 1'b1
    } action_t;

    // Input transaction payload.
    typedef struct packed {
        logic        action;
        logic [11:0] font_addr;
        logic [7:0]  font_byte;
        logic        line_start;
        logic [3:0]  glyph_row;
        logic [7:0]  char0;
        logic [7:0]  char1;
        logic [7:0]  char2;
        logic [7:0]  char3;
        logic        graphics_on;
        logic [31:0] graphics_word;
    } req_t;

    // Output transaction payload.
    typedef struct packed {
        logic [31:0] pixel_word;
        logic        last_word;
    } rsp_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] first_char;
        logic [9:0] chars_per_line;
        logic [7:0] gfx_start_word;
        logic [7:0] gfx_len_words;
    } cfg_t;

    // Per-word control carried alongside the font read.
    typedef struct packed {
        logic [31:0] gfx_word;
        logic [2:0]  keep;
        logic        last;
    } ctl_t;

endpackage

// ----- hdl/tlcr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module tlcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tlcr_cfg.sv -----
// APB-style configuration registers of the rasterizer.
module tlcr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlcr_pkg::PADDR_W-1:0] paddr,
    input  logic [tlcr_pkg::PDATA_W-1:0] pwdata,
    output logic [tlcr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output tlcr_pkg::cfg_t               cfg
);

    import tlcr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FIRST_CHAR:     cfg_next.first_char     = pwdata[7:0];
                REG_CHARS_PER_LINE: cfg_next.chars_per_line = pwdata[9:0];
                REG_GFX_START_WORD: cfg_next.gfx_start_word = pwdata[7:0];
                REG_GFX_LEN_WORDS:  cfg_next.gfx_len_words  = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_char     <= FIRST_CHAR_RST;
            cfg_reg.chars_per_line <= CHARS_PER_LINE_RST;
            cfg_reg.gfx_start_word <= GFX_START_RST;
            cfg_reg.gfx_len_words  <= GFX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (idx)
            REG_FIRST_CHAR:     prdata = PDATA_W'(cfg_reg.first_char);
            REG_CHARS_PER_LINE: prdata = PDATA_W'(cfg_reg.chars_per_line);
            REG_GFX_START_WORD: prdata = PDATA_W'(cfg_reg.gfx_start_word);
            REG_GFX_LEN_WORDS:  prdata = PDATA_W'(cfg_reg.gfx_len_words);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/tlcr_seq.sv -----
// Line sequencer: glyph address generation and the per-line word counters.
module tlcr_seq #(
    parameter int ROW_BITS    = 4,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tlcr_pkg::cfg_t      cfg,
    input  tlcr_pkg::req_t      req,
    input  logic                step,
    output logic [tlcr_pkg::CHARS_PER_WORD-1:0][$clog2(GLYPH_COUNT)+ROW_BITS-1:0] rd_addr,
    output tlcr_pkg::ctl_t      ctl
);

    import tlcr_pkg::*;

    localparam int GB = $clog2(GLYPH_COUNT);

    // Character code modulo glyph count, worked out at elaboration.
    logic [GB-1:0] mod_tab [256];
    for (genvar i = 0; i < 256; i++)
    begin : g_mod
        assign mod_tab[i] = GB'(i % GLYPH_COUNT);
    end

    logic [CHARS_PER_WORD-1:0][7:0] codes;
    logic [GB-1:0]                  first_mod;
    logic [ROW_BITS-1:0]            row;

    assign codes     = {req.char3, req.char2, req.char1, req.char0};
    assign first_mod = mod_tab[cfg.first_char];
    assign row       = ROW_BITS'(req.glyph_row);

    // Glyph index per character: difference of residues, wrapped once.
    for (genvar c = 0; c < CHARS_PER_WORD; c++)
    begin : g_addr
        logic [GB:0]   diff;
        logic [GB-1:0] glyph;
        always_comb
        begin
            diff = {1'b0, mod_tab[codes[c]]} - {1'b0, first_mod};
            if (diff[GB])
            begin
                glyph = diff[GB-1:0] + GB'(GLYPH_COUNT);
            end
            else
            begin
                glyph = diff[GB-1:0];
            end
            rd_addr[c] = {glyph, row};
        end
    end

    logic [7:0] wp_reg, wp_next, wp_eff;
    logic [9:0] cr_reg, cr_next, cr_eff;
    logic [7:0] gr_reg, gr_next, gr_eff;
    logic       apply;
    logic       last;

    // Line counters: a line start reloads them, then each word advances them.
    always_comb
    begin
        if (req.line_start)
        begin
            wp_eff = '0;
            cr_eff = cfg.chars_per_line;
            gr_eff = req.graphics_on ? cfg.gfx_len_words : '0;
        end
        else
        begin
            wp_eff = wp_reg;
            cr_eff = cr_reg;
            gr_eff = gr_reg;
        end

        apply = (wp_eff >= cfg.gfx_start_word) && (gr_eff != '0);
        last  = (cr_eff <= 10'(CHARS_PER_WORD));

        ctl.gfx_word = apply ? req.graphics_word : '0;
        ctl.last     = last;
        ctl.keep     = last ? cr_eff[2:0] : 3'(CHARS_PER_WORD);

        wp_next = wp_reg;
        cr_next = cr_reg;
        gr_next = gr_reg;
        if (step)
        begin
            gr_next = gr_eff - 8'(apply);
            if (last)
            begin
                cr_next = '0;
                wp_next = wp_eff;
            end
            else
            begin
                cr_next = cr_eff - 10'(CHARS_PER_WORD);
                wp_next = (wp_eff != WORD_POS_MAX) ? wp_eff + 8'd1 : wp_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            cr_reg <= '0;
            gr_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            cr_reg <= cr_next;
            gr_reg <= gr_next;
        end
    end

endmodule

// ----- hdl/text_line_char_rasterizer_top.sv -----
// Top level of the text line character rasterizer.
//
// Takes one transaction per clock when not stalled, font writes and character
// groups alike, and delivers one pixel word per character group via stage one
// and the output register. The rate is set by the font lookup: the glyph store
// is held in four identical copies of GLYPH_COUNT * 2^ROW_BITS bytes, one read
// port per character, and every font write updates all four copies. A font
// write followed in the next cycle by a group that reads the same row sees the
// new byte. Font entries hold no reset value and get no clearing pass; the
// line counters and registers reset at once. A full output register lets the
// next group enter while a result still waits to be taken.
module text_line_char_rasterizer_top #(
    parameter int ROW_BITS    = 4,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  tlcr_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output tlcr_pkg::rsp_t               rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlcr_pkg::PADDR_W-1:0] paddr,
    input  logic [tlcr_pkg::PDATA_W-1:0] pwdata,
    output logic [tlcr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import tlcr_pkg::*;

    localparam int AW         = $clog2(GLYPH_COUNT) + ROW_BITS;
    localparam int FONT_DEPTH = GLYPH_COUNT << ROW_BITS;

    cfg_t cfg;
    ctl_t ctl;
    logic [CHARS_PER_WORD-1:0][AW-1:0]     rd_addr;
    logic [CHARS_PER_WORD-1:0][BYTE_W-1:0] rd_data;

    logic accept, step, font_we, s1_go;
    logic s1_valid_reg, s1_valid_next;
    ctl_t s1_ctl_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;
    rsp_t out_next;

    // Configuration registers.
    tlcr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake and pipeline advance.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_go;
    assign accept    = req_valid && req_ready;
    assign step      = accept && (req.action == ACT_RASTER);
    assign font_we   = accept && (req.action == ACT_FONT_WRITE)
                       && (32'(req.font_addr) < FONT_DEPTH);

    // Address generation and line counters.
    tlcr_seq #(
        .ROW_BITS    (ROW_BITS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .step    (step),
        .rd_addr (rd_addr),
        .ctl     (ctl)
    );

    // One font copy per character lane.
    for (genvar c = 0; c < CHARS_PER_WORD; c++)
    begin : g_font
        tlcr_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (FONT_DEPTH)
        ) u_font (
            .clk   (clk),
            .we    (font_we),
            .waddr (AW'(req.font_addr)),
            .wdata (req.font_byte),
            .re    (step),
            .raddr (rd_addr[c]),
            .rdata (rd_data[c])
        );
    end

    // Stage one holds the word control while the font read completes.
    assign s1_valid_next = step ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_ctl_reg <= ctl;
        end
    end

    // Pack the rows, merge the overlay and clear bytes past the line end.
    always_comb
    begin
        for (int i = 0; i < CHARS_PER_WORD; i++)
        begin
            out_next.pixel_word[i*BYTE_W +: BYTE_W] =
                (rd_data[i] | s1_ctl_reg.gfx_word[i*BYTE_W +: BYTE_W])
                & {BYTE_W{(3'(i) < s1_ctl_reg.keep)}};
        end
        out_next.last_word = s1_ctl_reg.last;
    end

    // Output register.
    assign out_valid_next = s1_go ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A font write never puts a word into the pipeline.
    a_font_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == ACT_FONT_WRITE) && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("font write created a pipeline entry");

    // An empty stage one always takes a new transaction.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req_ready)
        else $error("input stalled with empty pipeline");

    // A blocked stage one keeps its word control.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_ctl_reg)))
        else $error("stalled stage one lost its contents");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the text line character rasterizer.
module tb;
    import tlcr_pkg::*;

    localparam int FONT_DEPTH    = 4096;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT     = 8 * 400000;

    // Output stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_RHYTHM,
        RX_STARVED
    } rx_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    text_line_char_rasterizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow of the configuration registers.
    logic [7:0] cfg_first_char     = FIRST_CHAR_RST;
    logic [9:0] cfg_chars_per_line = CHARS_PER_LINE_RST;
    logic [7:0] cfg_gfx_start_word = GFX_START_RST;
    logic [7:0] cfg_gfx_len_words  = GFX_LEN_RST;

    // Predicted font contents and line counters.
    logic [7:0] glyph_rows [0:FONT_DEPTH-1];
    logic [7:0] line_pos     = '0;
    logic [9:0] chars_left   = '0;
    logic [7:0] overlay_left = '0;

    // Transactions waiting to be sent and pixel words waiting to arrive.
    req_t raster_feed [$];
    rsp_t pixel_words_due [$];

    // Font entries that some queued write has already filled.
    bit         font_set [0:FONT_DEPTH-1];
    logic [7:0] palette [0:15];
    int         queued_items = 0;

    int errors           = 0;
    int sent_items       = 0;
    int font_writes_sent = 0;
    int words_checked    = 0;
    int settings_run     = 0;

    bit       req_fire     = 1'b0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    bit       hold_request = 1'b0;
    int       hold_left    = 0;
    rx_mode_t stall_mode   = RX_OPEN;
    int       mode_left    = 0;
    int       rx_cycle     = 0;

    // Font store address of one character row under the current first character.
    function automatic logic [11:0] font_slot(input logic [7:0] code, input logic [3:0] row);
        logic [7:0] glyph;
        glyph = code - cfg_first_char;
        return {glyph, row};
    endfunction

    // Applies one accepted transaction; returns 1 with the pixel word it produces.
    function automatic bit rasterize_item(input req_t it, output rsp_t word);
        logic [7:0]  codes [0:3];
        logic [31:0] pix;
        int          k;
        word = '0;
        if (it.action == ACT_FONT_WRITE) begin
            glyph_rows[it.font_addr] = it.font_byte;
            return 1'b0;
        end
        if (it.line_start) begin
            line_pos     = '0;
            chars_left   = cfg_chars_per_line;
            overlay_left = it.graphics_on ? cfg_gfx_len_words : 8'd0;
        end
        codes[0] = it.char0;
        codes[1] = it.char1;
        codes[2] = it.char2;
        codes[3] = it.char3;
        pix = '0;
        for (k = 0; k < CHARS_PER_WORD; k++)
        begin
            pix[k*BYTE_W +: BYTE_W] = glyph_rows[font_slot(codes[k], it.glyph_row)];
        end
        // Graphics overlay inside the window while overlay words remain.
        if (line_pos >= cfg_gfx_start_word && overlay_left != 0) begin
            pix |= it.graphics_word;
            overlay_left--;
        end
        // The last word keeps only the bytes of the characters still left.
        if (chars_left <= CHARS_PER_WORD) begin
            if (chars_left < CHARS_PER_WORD)
                pix &= ~(32'hFFFF_FFFF << (chars_left * BYTE_W));
            chars_left     = '0;
            word.last_word = 1'b1;
        end
        else begin
            chars_left -= CHARS_PER_WORD;
            if (line_pos != WORD_POS_MAX)
                line_pos++;
        end
        word.pixel_word = pix;
        return 1'b1;
    endfunction

    function automatic req_t noise_item();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(req_t)-1:0];
    endfunction

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 3) != 0)
            return palette[$urandom_range(0, 15)];
        return 8'($urandom());
    endfunction

    task automatic push_font_write(input logic [11:0] addr, input logic [7:0] value);
        req_t it;
        it           = noise_item();
        it.action    = ACT_FONT_WRITE;
        it.font_addr = addr;
        it.font_byte = value;
        font_set[addr] = 1'b1;
        raster_feed.push_back(it);
        queued_items++;
    endtask

    // Queues one character group, loading any font row it reads that was never written.
    task automatic push_group(input bit first, input logic [3:0] row,
                              input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] c3,
                              input bit gfx, input logic [31:0] overlay);
        req_t       it;
        logic [7:0] codes [0:3];
        int         k;
        codes[0] = c0;
        codes[1] = c1;
        codes[2] = c2;
        codes[3] = c3;
        for (k = 0; k < CHARS_PER_WORD; k++)
        begin
            if (!font_set[font_slot(codes[k], row)])
                push_font_write(font_slot(codes[k], row), 8'($urandom()));
        end
        it               = noise_item();
        it.action        = ACT_RASTER;
        it.line_start    = first;
        it.glyph_row     = row;
        it.char0         = c0;
        it.char1         = c1;
        it.char2         = c2;
        it.char3         = c3;
        it.graphics_on   = gfx;
        it.graphics_word = overlay;
        raster_feed.push_back(it);
        queued_items++;
    endtask

    // Queues one raster line: mostly complete, sometimes cut short or run past its end.
    task automatic queue_line();
        int         words;
        int         count;
        int         shape;
        int         k;
        logic [3:0] row;
        bit         gfx;
        words = (cfg_chars_per_line + 3) / 4;
        shape = $urandom_range(0, 9);
        count = words;
        if (shape == 8)
            count = $urandom_range(1, words);
        else if (shape == 9)
            count = words + $urandom_range(1, 3);
        row = 4'($urandom());
        gfx = ($urandom_range(0, 2) != 0);
        for (k = 0; k < count; k++)
        begin
            // Occasional font rewrite, either anywhere or on a row this line uses.
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_font_write(12'($urandom()), 8'($urandom()));
                else
                    push_font_write(font_slot(pick_code(), row), 8'($urandom()));
            end
            push_group(k == 0, row, pick_code(), pick_code(), pick_code(), pick_code(),
                       gfx, $urandom());
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_FIRST_CHAR:     cfg_first_char     = value[7:0];
            REG_CHARS_PER_LINE: cfg_chars_per_line = value[9:0];
            REG_GFX_START_WORD: cfg_gfx_start_word = value[7:0];
            REG_GFX_LEN_WORDS:  cfg_gfx_len_words  = value[7:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_check(input reg_idx_t idx, input logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== want) begin
            $error("register %s: expected %h, got %h", idx.name(), want, prdata);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] first, input logic [9:0] per_line,
                                 input logic [7:0] gfx_start, input logic [7:0] gfx_len);
        reg_write(REG_FIRST_CHAR, 32'(first));
        reg_write(REG_CHARS_PER_LINE, 32'(per_line));
        reg_write(REG_GFX_START_WORD, 32'(gfx_start));
        reg_write(REG_GFX_LEN_WORDS, 32'(gfx_len));
        reg_check(REG_FIRST_CHAR, 32'(cfg_first_char));
        reg_check(REG_CHARS_PER_LINE, 32'(cfg_chars_per_line));
        reg_check(REG_GFX_START_WORD, 32'(cfg_gfx_start_word));
        reg_check(REG_GFX_LEN_WORDS, 32'(cfg_gfx_len_words));
        settings_run++;
    endtask

    // Waits until every queued transaction is sent and every pixel word has arrived.
    task automatic wait_idle();
        while (raster_feed.size() != 0 || req_valid || pixel_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic new_palette();
        int k;
        for (k = 0; k < 16; k++)
        begin
            palette[k] = 8'($urandom());
        end
        queued_items = 0;
    endtask

    initial begin
        forever #4 clk = ~clk;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (raster_feed.size() != 0) begin
                req       <= raster_feed.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall patterns that change every so often, plus long hold-offs on request.
    always @(negedge clk) begin
        logic take;
        rx_cycle++;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 120);
            end
            mode_left--;
            case (stall_mode)
                RX_OPEN:   take = 1'b1;
                RX_COIN:   take = 1'($urandom_range(0, 1));
                RX_RHYTHM: take = (rx_cycle % 4) != 0;
                default:   take = ($urandom_range(0, 7) == 0);
            endcase
        end
        rsp_ready <= take;
    end

    // Monitor: checks each output transaction, then predicts from each input transaction.
    always @(posedge clk) begin
        rsp_t due;
        rsp_t word;
        req_fire = rst_n && req_valid && req_ready;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pixel_words_due.size() == 0) begin
                $error("pixel word %h arrived with none expected", rsp.pixel_word);
                errors++;
            end
            else begin
                due = pixel_words_due.pop_front();
                if (rsp.pixel_word !== due.pixel_word) begin
                    $error("pixel_word: expected %h, got %h", due.pixel_word, rsp.pixel_word);
                    errors++;
                end
                if (rsp.last_word !== due.last_word) begin
                    $error("last_word: expected %b, got %b", due.last_word, rsp.last_word);
                    errors++;
                end
                words_checked++;
            end
        end
        if (req_fire) begin
            sent_items++;
            if (req.action == ACT_FONT_WRITE)
                font_writes_sent++;
            if (rasterize_item(req, word))
                pixel_words_due.push_back(word);
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int ph;
        int budget;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, with the receiver held off while the sender keeps offering.
        new_palette();
        while (queued_items < 40)
            queue_line();
        hold_request = 1'b1;
        wait_idle();

        // Directed groups: code extremes, glyph wrap, window edge, exactly four left.
        apply_setting(8'd250, 10'd8, 8'd1, 8'd1);
        push_font_write(12'h000, 8'hFF);
        push_font_write(12'hFFF, 8'h81);
        push_group(1'b1, 4'd0, 8'd250, 8'd0, 8'd255, 8'd128, 1'b1, 32'hFFFF_FFFF);
        push_group(1'b0, 4'd15, 8'd249, 8'd249, 8'd0, 8'd255, 1'b1, 32'hA5A5_5A5A);
        // Past the end of the line the word is blank.
        push_group(1'b0, 4'd15, 8'd250, 8'd249, 8'd250, 8'd249, 1'b1, 32'hFFFF_FFFF);
        push_group(1'b1, 4'd0, 8'd250, 8'd250, 8'd250, 8'd250, 1'b0, 32'hFFFF_FFFF);
        // A new line starts before the previous one ended.
        push_group(1'b1, 4'd15, 8'd0, 8'd255, 8'd249, 8'd250, 1'b1, 32'h0000_0000);
        wait_idle();

        // Directed groups: overlay from word zero, one character left clips the overlay.
        apply_setting(8'd0, 10'd5, 8'd0, 8'd255);
        push_group(1'b1, 4'd7, 8'd0, 8'd255, 8'd1, 8'd128, 1'b1, 32'h0F0F_0F0F);
        push_group(1'b0, 4'd7, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 32'hFFFF_FFFF);
        push_group(1'b0, 4'd7, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 32'hFFFF_FFFF);
        wait_idle();

        // Random lines under a series of settings, extremes among them.
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin
                    apply_setting(8'd0, 10'd1, 8'd0, 8'd255);
                    budget = 40;
                end
                1: begin
                    apply_setting(8'd255, 10'd1023, 8'd255, 8'd255);
                    budget = 260;
                end
                2: begin
                    apply_setting(8'($urandom()), 10'd4, 8'd0, 8'd0);
                    budget = 40;
                end
                5: begin
                    apply_setting(8'd128, 10'd13, 8'd2, 8'd255);
                    budget = 60;
                end
                default: begin
                    apply_setting(8'($urandom()), 10'($urandom_range(5, 40)),
                                  8'($urandom_range(0, 6)), 8'($urandom_range(1, 10)));
                    budget = 60;
                end
            endcase
            new_palette();
            while (queued_items < budget)
                queue_line();
            if (ph == 1)
                hold_request = 1'b1;
            wait_idle();
        end

        $display("tb: %0d transactions sent (%0d font writes), %0d pixel words checked",
                 sent_items, font_writes_sent, words_checked);
        $display("tb: %0d register settings, lines of 1 to 1023 characters with overlays",
                 settings_run);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tlcr_pkg.sv
hdl/tlcr_ram.sv
hdl/tlcr_cfg.sv
hdl/tlcr_seq.sv
hdl/text_line_char_rasterizer_top.sv
verif/tb.sv
